// File: src/bsap_pkg.sv
// Shared types and constants for the bulk string array parser.
// No dependencies; imported by bulk_string_array_parser.
package bsap_pkg;

    // Default limits on the announced element count and element length.
    localparam longint unsigned DEF_MAX_ELEMENTS = 64'd1024;
    localparam longint unsigned DEF_MAX_LENGTH   = 64'd65535;

    // Fixed widths of the result fields.
    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 10;
    localparam int TOTAL_W  = 11;
    localparam int LENGTH_W = 16;
    localparam int ERROR_W  = 3;

    // Framing characters.
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ELEM_DONE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd4;

    // Error codes.
    localparam logic [ERROR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERROR_W-1:0] ERR_NO_STAR   = 3'd1;
    localparam logic [ERROR_W-1:0] ERR_BAD_COUNT = 3'd2;
    localparam logic [ERROR_W-1:0] ERR_BAD_LEN   = 3'd3;
    localparam logic [ERROR_W-1:0] ERR_MISMATCH  = 3'd4;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_STAR,
        PH_COUNT,
        PH_COUNT_LF,
        PH_DOLLAR,
        PH_LEN,
        PH_LEN_LF,
        PH_PAYLOAD,
        PH_PAY_CR,
        PH_PAY_LF
    } phase_t;

endpackage

// File: src/bulk_string_array_parser.sv
// Top level of the bulk string array parser: byte-wide request framing and checking.
// Depends on bsap_pkg for phase type, framing characters, result kinds and error codes.
//
// The parser takes one byte of a request stream per transaction on the s_ channel and
// gives exactly one result transaction on the m_ channel for every byte. A command is
// '*', a decimal element count and CR LF; each element is '$', a decimal length, CR LF,
// that many payload bytes and CR LF. Payload bytes come out as kind 2 with their element
// index, the closing LF of each element as kind 3, and the header LF as kind 1; the
// byte that ends the command also sets command_done (a zero count ends it at the header).
// A framing violation gives kind 4 with an error code and the parser goes back to
// expecting '*'. Each byte passes through an input register, combinational decode and
// counter update, and a result register that offers the result on the m_ channel;
// the block takes one byte per cycle unless m_ready stalls the result register.
// The only loop is the parser state register itself. s_ready is low
// only while the input register holds a byte that the stalled result register cannot
// take; a result waiting on m_ready does not keep the next byte out of the input
// register. Counts above MAX_ELEMENTS and lengths above MAX_LENGTH are flagged as bad.
module bulk_string_array_parser
    import bsap_pkg::*;
#(
    parameter longint unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter longint unsigned MAX_LENGTH   = DEF_MAX_LENGTH
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_data_byte,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [KIND_W-1:0]   m_kind,
    output logic [BYTE_W-1:0]   m_payload_byte,
    output logic [INDEX_W-1:0]  m_element_index,
    output logic [TOTAL_W-1:0]  m_element_total,
    output logic [LENGTH_W-1:0] m_element_length,
    output logic                m_command_done,
    output logic [ERROR_W-1:0]  m_error_code
);

    // Internal counter widths follow the limits. The accumulator holds any value up to
    // the larger limit; a digit step can grow it by four bits before the range check.
    localparam longint unsigned MAX_NUM = (MAX_ELEMENTS > MAX_LENGTH) ? MAX_ELEMENTS
                                                                      : MAX_LENGTH;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 64'd1);
    localparam int LEN_W  = $clog2(MAX_LENGTH + 64'd1);
    localparam int ACC_W  = $clog2(MAX_NUM + 64'd1);
    localparam int PROD_W = ACC_W + 4;

    localparam logic [PROD_W-1:0] LIMIT_CNT = PROD_W'(MAX_ELEMENTS);
    localparam logic [PROD_W-1:0] LIMIT_LEN = PROD_W'(MAX_LENGTH);

    // Input register.
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Parser state.
    phase_t            phase_reg, phase_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              digit_seen_reg, digit_seen_next;
    logic [CNT_W-1:0]  elem_exp_reg, elem_exp_next;
    logic [CNT_W-1:0]  elem_done_reg, elem_done_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]  pay_seen_reg, pay_seen_next;

    // Result register.
    logic                m_valid_reg;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [BYTE_W-1:0]   pay_byte_reg, pay_byte_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [LENGTH_W-1:0] length_reg, length_next;
    logic                done_reg, done_next;
    logic [ERROR_W-1:0]  err_reg, err_next;

    logic              out_free;
    logic              step;
    logic              is_digit;
    logic [PROD_W-1:0] acc_prod;
    logic [PROD_W-1:0] digit_ext;
    logic [CNT_W-1:0]  done_inc;
    logic [LEN_W-1:0]  seen_inc;
    logic [CNT_W-1:0]  idx_val;
    logic [63:0]       idx_wide;
    logic [63:0]       total_wide;
    logic [63:0]       length_wide;

    // The result register can load when it is empty or its transaction completes now.
    assign out_free = !m_valid_reg || m_ready;
    assign step     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    assign is_digit  = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign digit_ext = PROD_W'(in_byte_reg - CH_ZERO);
    // Times ten as two shifts and an add, then the new digit.
    assign acc_prod  = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1) + digit_ext;
    assign done_inc  = elem_done_reg + CNT_W'(1);
    assign seen_inc  = pay_seen_reg + LEN_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_STAR;
            acc_reg        <= '0;
            digit_seen_reg <= 1'b0;
            elem_exp_reg   <= '0;
            elem_done_reg  <= '0;
            exp_len_reg    <= '0;
            pay_seen_reg   <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            digit_seen_reg <= digit_seen_next;
            elem_exp_reg   <= elem_exp_next;
            elem_done_reg  <= elem_done_next;
            exp_len_reg    <= exp_len_next;
            pay_seen_reg   <= pay_seen_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        digit_seen_next = digit_seen_reg;
        elem_exp_next   = elem_exp_reg;
        elem_done_next  = elem_done_reg;
        exp_len_next    = exp_len_reg;
        pay_seen_next   = pay_seen_reg;
        kind_next       = KIND_NONE;
        pay_byte_next   = '0;
        done_next       = 1'b0;
        err_next        = ERR_NONE;
        idx_val         = elem_done_reg;

        unique case (phase_reg)
            PH_STAR: begin
                if (in_byte_reg == CH_STAR) begin
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                    phase_next      = PH_COUNT;
                end else begin
                    err_next = ERR_NO_STAR;
                end
            end
            PH_COUNT: begin
                if (is_digit) begin
                    acc_next        = acc_prod[ACC_W-1:0];
                    digit_seen_next = 1'b1;
                    if (acc_prod > LIMIT_CNT) begin
                        err_next = ERR_BAD_COUNT;
                    end
                end else if (in_byte_reg == CH_CR && digit_seen_reg) begin
                    phase_next = PH_COUNT_LF;
                end else begin
                    err_next = ERR_BAD_COUNT;
                end
            end
            PH_COUNT_LF: begin
                if (in_byte_reg == CH_LF) begin
                    // The accumulator was checked against the count limit, so it fits.
                    elem_exp_next  = CNT_W'(acc_reg);
                    elem_done_next = '0;
                    idx_val        = '0;
                    kind_next      = KIND_HEADER;
                    if (acc_reg == '0) begin
                        done_next  = 1'b1;
                        phase_next = PH_STAR;
                    end else begin
                        phase_next = PH_DOLLAR;
                    end
                end else begin
                    err_next = ERR_BAD_COUNT;
                end
            end
            PH_DOLLAR: begin
                if (in_byte_reg == CH_DOLLAR) begin
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                    phase_next      = PH_LEN;
                end else begin
                    err_next = ERR_BAD_LEN;
                end
            end
            PH_LEN: begin
                if (is_digit) begin
                    acc_next        = acc_prod[ACC_W-1:0];
                    digit_seen_next = 1'b1;
                    if (acc_prod > LIMIT_LEN) begin
                        err_next = ERR_BAD_LEN;
                    end
                end else if (in_byte_reg == CH_CR && digit_seen_reg) begin
                    phase_next = PH_LEN_LF;
                end else begin
                    err_next = ERR_BAD_LEN;
                end
            end
            PH_LEN_LF: begin
                if (in_byte_reg == CH_LF) begin
                    exp_len_next  = LEN_W'(acc_reg);
                    pay_seen_next = '0;
                    phase_next    = (acc_reg == '0) ? PH_PAY_CR : PH_PAYLOAD;
                end else begin
                    err_next = ERR_BAD_LEN;
                end
            end
            PH_PAYLOAD: begin
                kind_next     = KIND_PAYLOAD;
                pay_byte_next = in_byte_reg;
                pay_seen_next = seen_inc;
                if (seen_inc >= exp_len_reg) begin
                    phase_next = PH_PAY_CR;
                end
            end
            PH_PAY_CR: begin
                if (in_byte_reg == CH_CR) begin
                    phase_next = PH_PAY_LF;
                end else begin
                    err_next = ERR_MISMATCH;
                end
            end
            PH_PAY_LF: begin
                if (in_byte_reg == CH_LF) begin
                    kind_next      = KIND_ELEM_DONE;
                    elem_done_next = done_inc;
                    if (done_inc >= elem_exp_reg) begin
                        done_next  = 1'b1;
                        phase_next = PH_STAR;
                    end else begin
                        phase_next = PH_DOLLAR;
                    end
                end else begin
                    err_next = ERR_MISMATCH;
                end
            end
            default: begin
                phase_next      = PH_STAR;
                acc_next        = '0;
                digit_seen_next = 1'b0;
                elem_exp_next   = '0;
                elem_done_next  = '0;
                exp_len_next    = '0;
                pay_seen_next   = '0;
            end
        endcase

        // The reported counters are those after this byte's update, taken before
        // an error wipes the state.
        idx_wide    = 64'(idx_val);
        total_wide  = 64'(elem_exp_next);
        length_wide = 64'(exp_len_next);
        index_next  = idx_wide[INDEX_W-1:0];
        total_next  = total_wide[TOTAL_W-1:0];
        length_next = length_wide[LENGTH_W-1:0];

        if (err_next != ERR_NONE) begin
            kind_next       = KIND_ERROR;
            pay_byte_next   = '0;
            done_next       = 1'b0;
            phase_next      = PH_STAR;
            acc_next        = '0;
            digit_seen_next = 1'b0;
            elem_exp_next   = '0;
            elem_done_next  = '0;
            exp_len_next    = '0;
            pay_seen_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_vld_reg;
        end
        if (step) begin
            kind_reg     <= kind_next;
            pay_byte_reg <= pay_byte_next;
            index_reg    <= index_next;
            total_reg    <= total_next;
            length_reg   <= length_next;
            done_reg     <= done_next;
            err_reg      <= err_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_payload_byte   = pay_byte_reg;
    assign m_element_index  = index_reg;
    assign m_element_total  = total_reg;
    assign m_element_length = length_reg;
    assign m_command_done   = done_reg;
    assign m_error_code     = err_reg;

    // An error always returns the parser to the start of a command.
    a_error_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && err_next != ERR_NONE |=> phase_reg == PH_STAR && elem_done_reg == '0)
        else $error("parser state not cleared after an error");

    // Payload counting never runs past the announced length.
    a_payload_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> pay_seen_reg < exp_len_reg)
        else $error("payload count reached the element length while in payload");

    // Completed elements never exceed the announced count.
    a_elem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        elem_done_reg <= elem_exp_reg)
        else $error("more elements completed than announced");

    // Command end is only signaled by a header or an element end.
    a_done_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command_done |-> m_kind == KIND_HEADER || m_kind == KIND_ELEM_DONE)
        else $error("command end on an unexpected result kind");

endmodule

// File: test/bulk_string_array_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bulk_string_array_parser: request framing, payload and errors.
// Depends on bsap_pkg and the parser RTL; holds its own scoreboard class and stimulus tasks.

import bsap_pkg::*;

// One result transaction, field for field as the m_ channel carries it.
typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [INDEX_W-1:0]  element_index;
    logic [TOTAL_W-1:0]  element_total;
    logic [LENGTH_W-1:0] element_length;
    logic                command_done;
    logic [ERROR_W-1:0]  error_code;
} parse_result_t;

// Tracks the parser state independently and keeps the results still owed by the block.
class parse_scoreboard;
    phase_t        phase;
    int unsigned   number_value;
    bit            digit_seen;
    int unsigned   total;
    int unsigned   elements_seen;
    int unsigned   announced_len;
    int unsigned   bytes_seen;
    parse_result_t pending[$];
    int unsigned   mismatches;

    function new();
        clear_state();
        mismatches = 0;
    endfunction

    function void clear_state();
        phase         = PH_STAR;
        number_value  = 0;
        digit_seen    = 1'b0;
        total         = 0;
        elements_seen = 0;
        announced_len = 0;
        bytes_seen    = 0;
    endfunction

    function int unsigned pending_count();
        return pending.size();
    endfunction

    // Works out the result that one accepted byte must produce and queues it.
    function void note_byte(logic [BYTE_W-1:0] b);
        parse_result_t       r;
        bit                  is_digit;
        logic [KIND_W-1:0]   kind;
        logic [ERROR_W-1:0]  err;
        logic [BYTE_W-1:0]   pay;
        logic                done;
        int unsigned         idx;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        kind = KIND_NONE;
        err  = ERR_NONE;
        pay  = '0;
        done = 1'b0;
        idx  = elements_seen;
        case (phase)
            PH_STAR: begin
                if (b == CH_STAR) begin
                    number_value = 0;
                    digit_seen   = 1'b0;
                    phase        = PH_COUNT;
                end else begin
                    err = ERR_NO_STAR;
                end
            end
            PH_COUNT: begin
                if (is_digit) begin
                    number_value = number_value * 10 + (b - CH_ZERO);
                    digit_seen   = 1'b1;
                    if (number_value > DEF_MAX_ELEMENTS) err = ERR_BAD_COUNT;
                end else if (b == CH_CR && digit_seen) begin
                    phase = PH_COUNT_LF;
                end else begin
                    err = ERR_BAD_COUNT;
                end
            end
            PH_COUNT_LF: begin
                if (b == CH_LF) begin
                    total         = number_value;
                    elements_seen = 0;
                    idx           = 0;
                    kind          = KIND_HEADER;
                    if (total == 0) begin
                        done  = 1'b1;
                        phase = PH_STAR;
                    end else begin
                        phase = PH_DOLLAR;
                    end
                end else begin
                    err = ERR_BAD_COUNT;
                end
            end
            PH_DOLLAR: begin
                if (b == CH_DOLLAR) begin
                    number_value = 0;
                    digit_seen   = 1'b0;
                    phase        = PH_LEN;
                end else begin
                    err = ERR_BAD_LEN;
                end
            end
            PH_LEN: begin
                if (is_digit) begin
                    number_value = number_value * 10 + (b - CH_ZERO);
                    digit_seen   = 1'b1;
                    if (number_value > DEF_MAX_LENGTH) err = ERR_BAD_LEN;
                end else if (b == CH_CR && digit_seen) begin
                    phase = PH_LEN_LF;
                end else begin
                    err = ERR_BAD_LEN;
                end
            end
            PH_LEN_LF: begin
                if (b == CH_LF) begin
                    announced_len = number_value;
                    bytes_seen    = 0;
                    phase = (announced_len == 0) ? PH_PAY_CR : PH_PAYLOAD;
                end else begin
                    err = ERR_BAD_LEN;
                end
            end
            PH_PAYLOAD: begin
                kind = KIND_PAYLOAD;
                pay  = b;
                bytes_seen++;
                if (bytes_seen >= announced_len) phase = PH_PAY_CR;
            end
            PH_PAY_CR: begin
                if (b == CH_CR) phase = PH_PAY_LF;
                else err = ERR_MISMATCH;
            end
            PH_PAY_LF: begin
                if (b == CH_LF) begin
                    kind = KIND_ELEM_DONE;
                    elements_seen++;
                    if (elements_seen >= total) begin
                        done  = 1'b1;
                        phase = PH_STAR;
                    end else begin
                        phase = PH_DOLLAR;
                    end
                end else begin
                    err = ERR_MISMATCH;
                end
            end
            default: clear_state();
        endcase
        // Counters are reported after the update but before an error clears them.
        r.element_index  = idx[INDEX_W-1:0];
        r.element_total  = total[TOTAL_W-1:0];
        r.element_length = announced_len[LENGTH_W-1:0];
        if (err != ERR_NONE) begin
            kind = KIND_ERROR;
            pay  = '0;
            done = 1'b0;
            clear_state();
        end
        r.kind         = kind;
        r.payload_byte = pay;
        r.command_done = done;
        r.error_code   = err;
        pending.insert(pending.size(), r);
    endfunction

    // Compares one accepted result with the oldest outstanding prediction.
    function void check_result(parse_result_t got);
        parse_result_t want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with no byte outstanding: kind %0d err %0d",
                         $time, got.kind, got.error_code);
        end else begin
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch (expected/actual) kind %0d/%0d byte %02h/%02h ",
                              "index %0d/%0d total %0d/%0d length %0d/%0d done %0b/%0b ",
                              "err %0d/%0d"}, $time,
                             want.kind, got.kind, want.payload_byte, got.payload_byte,
                             want.element_index, got.element_index,
                             want.element_total, got.element_total,
                             want.element_length, got.element_length,
                             want.command_done, got.command_done,
                             want.error_code, got.error_code);
            end
        end
    endfunction
endclass

module bulk_string_array_parser_tb;

    localparam int CLK_PERIOD = 4;
    localparam int BYTES_PER_PHASE = 330;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_data_byte = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [KIND_W-1:0]   m_kind;
    logic [BYTE_W-1:0]   m_payload_byte;
    logic [INDEX_W-1:0]  m_element_index;
    logic [TOTAL_W-1:0]  m_element_total;
    logic [LENGTH_W-1:0] m_element_length;
    logic                m_command_done;
    logic [ERROR_W-1:0]  m_error_code;

    parse_scoreboard     sb;
    parse_result_t       observed;

    // Percent chance per cycle that the sender holds back or the receiver stalls.
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         bytes_sent = 0;

    // Bytes of the request stream built up before they are sent.
    logic [BYTE_W-1:0]   stream[$];

    bulk_string_array_parser dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_payload_byte   (m_payload_byte),
        .m_element_index  (m_element_index),
        .m_element_total  (m_element_total),
        .m_element_length (m_element_length),
        .m_command_done   (m_command_done),
        .m_error_code     (m_error_code)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // The receiver stalls at random; with a stall chance of zero it is always ready.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    assign observed = {m_kind, m_payload_byte, m_element_index, m_element_total,
                       m_element_length, m_command_done, m_error_code};

    // Inputs only change just after a rising edge, so the handshake seen at the falling
    // edge is exactly the one that completes at the next rising edge.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(observed);
    end

    // Offers one byte and returns at the rising edge where the transaction completes.
    // Gaps are inserted before valid goes high; once raised, valid holds until accepted.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        sb.note_byte(b);
        bytes_sent++;
        @(posedge aclk);
    endtask

    task automatic flush_stream();
        while (stream.size() != 0) send_byte(stream.pop_front());
    endtask

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        stream.insert(stream.size(), b);
    endfunction

    function automatic void push_crlf();
        stream.insert(stream.size(), CH_CR);
        stream.insert(stream.size(), CH_LF);
    endfunction

    // Decimal digits of a value, optionally with leading zeros in front.
    function automatic void push_number(input int unsigned v, input int unsigned zeros);
        string digits;
        digits = $sformatf("%0d", v);
        repeat (zeros) stream.insert(stream.size(), CH_ZERO);
        for (int i = 0; i < digits.len(); i++) stream.insert(stream.size(), digits[i]);
    endfunction

    function automatic void push_header(input int unsigned count, input int unsigned zeros);
        push_byte(CH_STAR);
        push_number(count, zeros);
        push_crlf();
    endfunction

    function automatic void push_len(input int unsigned len, input int unsigned zeros);
        push_byte(CH_DOLLAR);
        push_number(len, zeros);
        push_crlf();
    endfunction

    function automatic void push_payload(input int unsigned n);
        repeat (n) stream.insert(stream.size(), 8'($urandom_range(255)));
    endfunction

    // Favors the bytes that steer the parser: markers, CR, LF and digits.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(7))
            0:       return CH_STAR;
            1:       return CH_DOLLAR;
            2:       return CH_CR;
            3:       return CH_LF;
            4:       return CH_ZERO;
            5:       return CH_NINE;
            6:       return CH_ZERO + 8'($urandom_range(9));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // A well-formed command with random sizes and content, sometimes damaged afterward
    // by replacing, inserting or cutting at a random position.
    function automatic void build_command();
        int unsigned count;
        int unsigned len;
        int unsigned roll;
        int unsigned pos;
        roll = $urandom_range(99);
        if (roll < 5) count = 0;
        else if (roll < 95) count = $urandom_range(1, 4);
        else count = $urandom_range(5, 20);
        push_header(count, ($urandom_range(99) < 10) ? $urandom_range(1, 3) : 0);
        for (int e = 0; e < count; e++) begin
            roll = $urandom_range(99);
            if (roll < 10) len = 0;
            else if (roll < 90) len = $urandom_range(1, 6);
            else len = $urandom_range(7, 40);
            push_len(len, ($urandom_range(99) < 10) ? $urandom_range(1, 3) : 0);
            push_payload(len);
            push_crlf();
        end
        if ($urandom_range(99) < 20) begin
            pos = $urandom_range(stream.size() - 1);
            case ($urandom_range(2))
                0:       stream[pos] = pick_byte();
                1:       stream.insert(pos, pick_byte());
                default: while (stream.size() > pos) void'(stream.pop_back());
            endcase
        end
    endfunction

    // Mostly well-formed commands; the rest are numbers near the limits and loose noise.
    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned roll;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                build_command();
            end else if (roll < 80) begin
                // Count near its limit, broken off by a byte that is no CR.
                push_byte(CH_STAR);
                push_number($urandom_range(1015, 1035), 0);
                push_byte(8'h21);
            end else if (roll < 88) begin
                // Length near its limit, broken off the same way.
                push_header(1, 0);
                push_byte(CH_DOLLAR);
                push_number($urandom_range(65525, 65545), 0);
                push_byte(8'h21);
            end else begin
                repeat ($urandom_range(1, 4)) push_byte(pick_byte());
            end
            flush_stream();
        end
    endtask

    initial begin
        int unsigned idle_tbl[4];
        int unsigned stall_tbl[4];
        idle_tbl  = '{0, 63, 0, 25};
        stall_tbl = '{0, 0, 63, 25};
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sequences, one special case each.
        push_header(0, 0);                          // zero count ends at the header
        push_byte(8'h78);                           // no count marker
        push_header(1, 0);                          // zero-length element
        push_len(0, 0);
        push_crlf();
        push_header(2, 0);                          // payload extremes, CR and LF as data
        push_len(3, 0);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_CR);
        push_crlf();
        push_len(1, 0);
        push_byte(CH_LF);
        push_crlf();
        push_byte(CH_STAR);                         // count CR with no digit
        push_byte(CH_CR);
        push_byte(CH_STAR);                         // sign in the count
        push_byte(8'h2D);
        push_byte(CH_STAR);                         // count LF missing
        push_byte(CH_ZERO + 8'd1);
        push_byte(CH_CR);
        push_byte(8'h78);
        push_byte(CH_STAR);                         // count one above the limit
        push_number(1025, 0);
        push_header(1024, 0);                       // largest count, then no '$'
        push_byte(8'h23);
        push_header(1, 0);                          // length CR with no digit
        push_byte(CH_DOLLAR);
        push_byte(CH_CR);
        push_header(1, 0);                          // letter inside the length
        push_byte(CH_DOLLAR);
        push_byte(CH_ZERO + 8'd1);
        push_byte(8'h61);
        push_header(1, 0);                          // largest length, LF missing
        push_byte(CH_DOLLAR);
        push_number(65535, 0);
        push_byte(CH_CR);
        push_byte(8'h5A);
        push_header(1, 0);                          // length one above the limit
        push_byte(CH_DOLLAR);
        push_number(65536, 0);
        push_header(1, 0);                          // too much payload
        push_len(1, 0);
        push_byte(8'h61);
        push_byte(8'h62);
        push_header(1, 0);                          // CR not followed by LF after payload
        push_len(1, 0);
        push_byte(8'h61);
        push_byte(CH_CR);
        push_byte(CH_CR);
        push_header(3, 3);                          // leading zeros, CRLF as payload
        push_len(2, 1);
        push_crlf();
        push_crlf();
        push_len(0, 0);
        push_crlf();
        push_len(1, 0);
        push_byte(CH_STAR);
        push_crlf();
        push_header(1, 0);                          // back-to-back commands
        push_len(0, 0);
        push_crlf();
        push_header(0, 0);
        flush_stream();

        // Random traffic under each pattern of idling and stalling.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_tbl[p];
            recv_stall_pct = stall_tbl[p];
            random_traffic(BYTES_PER_PHASE);
        end

        s_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Safety net against a hung handshake; far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
src/bsap_pkg.sv
src/bulk_string_array_parser.sv
test/bulk_string_array_parser_tb.sv
